>>> src/zeck_pkg.sv
// Package for the Zeckendorf encoder: widths, Fibonacci tables, state type.
`default_nettype none
package zeck_pkg;
    localparam int MaxDigits   = 90;
    localparam int ChunkDigits = 8;
    localparam int KW          = 63;
    localparam int LW          = 7;   // holds 0..MaxDigits+1
    localparam int VW          = 64;  // Fibonacci and sum values

    typedef logic [VW-1:0] val_t;
    typedef logic [LW-1:0] len_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SEARCH, ST_DIGIT, ST_SEND, ST_OOR
    } state_t;

    // F(i), F(0)=0, F(1)=1
    function automatic val_t fib(input int i);
        val_t a;
        val_t b;
        val_t t;
        a = '0;
        b = 64'd1;
        for (int j = 0; j < 100; j++) begin
            if (j < i) begin
                t = a + b;
                a = b;
                b = t;
            end
        end
        return a;
    endfunction

    // S(i) = F(1)+..+F(i) = F(i+2)-1
    function automatic val_t fsum(input int i);
        return fib(i + 2) - 64'd1;
    endfunction
endpackage
`default_nettype wire

>>> src/zeck_cell.sv
// One digit cell: holds one digit and shifts it toward the output end.
`default_nettype none
module zeck_cell (
    input  wire  clk,
    input  wire  rst_n,
    input  wire  shift,
    input  wire  d_in,
    output logic d_out
);
    logic dig_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dig_reg <= 1'b0;
        else if (shift)
            dig_reg <= d_in;
    end

    assign d_out = dig_reg;
endmodule
`default_nettype wire

>>> src/zeckendorf_encoder.sv
// Top level of the Zeckendorf encoder: controller plus a row of digit cells.
// Usage:
//   Pulse start with k while busy is low; the rank k is taken at that edge.
//   busy then stays high until the last chunk has been sent.
//   The block first searches the string length: one Fibonacci prefix sum is
//   compared per cycle. Then one digit is decided per cycle (one compare
//   and subtract against F(r+1)). Each digit enters the row of MaxDigits
//   cells at cell len-1 while the row shifts toward cell 0, so after the
//   digit phase the first digit sits at cell 0.
//   Chunks are then sent one per cycle from cells 0..7: strobe is high for
//   one cycle with digits, digit_count and last; the row shifts by
//   ChunkDigits each cycle.
//   A rank of zero or above S(90) yields one result with out_of_range set,
//   in the cycle after the transfer.
//   Results are on the ports for exactly one cycle; the receiver cannot
//   stall, so nothing is held back. Reset clears control and the cells.
`default_nettype none
module zeckendorf_encoder (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [62:0] k,
    output logic        strobe,
    output logic [7:0]  digits,
    output logic [3:0]  digit_count,
    output logic        out_of_range,
    output logic        last
);
    import zeck_pkg::*;

    state_t state_reg, state_next;
    val_t   nth_reg, nth_next;
    len_t   len_reg, len_next;
    len_t   cnt_reg, cnt_next;   // search index / digits done / digits left
    logic   prev_reg, prev_next;
    logic   shift_one, shift_chunk;
    logic   new_dig;

    logic [MaxDigits-1:0] cells;
    logic [7:0] chunk_bits;

    // Constant table lookups
    val_t sum_at, fib_at, sum_prev;
    always_comb
    begin
        sum_at = '0;
        sum_prev = '0;
        fib_at = '0;
        for (int i = 0; i <= MaxDigits; i++) begin
            if (cnt_reg == len_t'(i)) sum_at = fsum(i);
            if (len_reg == len_t'(i)) sum_prev = fsum(i - 1 < 0 ? 0 : i - 1);
        end
        for (int i = 0; i <= MaxDigits + 1; i++)
            if (len_t'(i) == len_reg - cnt_reg + len_t'(1)) fib_at = fib(i);
    end

    // Cell row: cell i takes from cell i+ChunkDigits on chunk shift,
    // from cell i+1 on digit shift; cell len-1 takes the new digit.
    genvar g;
    generate
        for (g = 0; g < MaxDigits; g++)
        begin : g_cell
            logic din;
            logic nbr;
            logic far;
            if (g < MaxDigits - 1)
            begin : g_nbr
                assign nbr = cells[g + 1];
            end
            else
            begin : g_nbr_top
                assign nbr = 1'b0;
            end
            if (g + ChunkDigits < MaxDigits)
            begin : g_far
                assign far = cells[g + ChunkDigits];
            end
            else
            begin : g_far_top
                assign far = 1'b0;
            end
            always_comb
            begin
                if (shift_chunk)
                    din = far;
                else if (len_reg == len_t'(g + 1))
                    din = new_dig;
                else
                    din = nbr;
            end
            zeck_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift_one | shift_chunk),
                .d_in  (din),
                .d_out (cells[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
            cnt_reg   <= '0;
            prev_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            prev_reg  <= prev_next;
        end
    end

    always_ff @(posedge clk)
        nth_reg <= nth_next;

    always_comb
    begin
        state_next   = state_reg;
        nth_next     = nth_reg;
        len_next     = len_reg;
        cnt_next     = cnt_reg;
        prev_next    = prev_reg;
        shift_one    = 1'b0;
        shift_chunk  = 1'b0;
        new_dig      = 1'b0;
        busy         = (state_reg != ST_IDLE);
        strobe       = 1'b0;
        digits       = '0;
        digit_count  = '0;
        out_of_range = 1'b0;
        last         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    nth_next = {1'b0, k};
                    cnt_next = len_t'(1);
                    if (k == '0 || {1'b0, k} > fsum(MaxDigits))
                        state_next = ST_OOR;
                    else
                        state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (sum_at >= nth_reg || cnt_reg == len_t'(MaxDigits))
                begin
                    len_next   = cnt_reg;
                    state_next = ST_DIGIT;
                    cnt_next   = '0;
                    prev_next  = 1'b0;
                end
                else
                    cnt_next = cnt_reg + len_t'(1);
            end
            ST_DIGIT:
            begin
                // cnt_reg = digits done; current position cur = cnt_reg+1
                shift_one = 1'b1;
                if (cnt_reg == '0)
                begin
                    new_dig  = 1'b1;
                    nth_next = nth_reg - sum_prev;
                end
                else if (cnt_reg == len_t'(1))
                    new_dig = 1'b0;
                else if (!prev_reg && nth_reg > fib_at)
                begin
                    new_dig   = 1'b1;
                    nth_next  = nth_reg - fib_at;
                    prev_next = 1'b1;
                end
                else
                    prev_next = 1'b0;
                if (cnt_reg + len_t'(1) == len_reg)
                begin
                    state_next = ST_SEND;
                    cnt_next   = len_reg;
                end
                else
                    cnt_next = cnt_reg + len_t'(1);
            end
            ST_SEND:
            begin
                // remaining digits sit at cells[0 .. cnt_reg-1]
                strobe = 1'b1;
                shift_chunk = 1'b1;
                if (cnt_reg <= len_t'(ChunkDigits))
                begin
                    digit_count = 4'(cnt_reg);
                    last        = 1'b1;
                    state_next  = ST_IDLE;
                    cnt_next    = '0;
                end
                else
                begin
                    digit_count = 4'(ChunkDigits);
                    cnt_next    = cnt_reg - len_t'(ChunkDigits);
                end
                digits = chunk_bits;
            end
            ST_OOR:
            begin
                strobe       = 1'b1;
                out_of_range = 1'b1;
                last         = 1'b1;
                state_next   = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Chunk view: the next digits always sit at cells 0..7
    always_comb
    begin
        chunk_bits = '0;
        for (int j = 0; j < 8; j++)
            if (len_t'(j) < cnt_reg && j < ChunkDigits)
                chunk_bits[7-j] = cells[j];
    end
endmodule
`default_nettype wire
